@@ hw/rtl/nrkf_pkg.sv @@
// Package for the normalized row key frequency block.
// Holds widths, the sequencer state type, shared structs and the key normalizing function.
// No dependencies.
`timescale 1ns / 1ps

package nrkf_pkg;

  localparam int ROW_BITS   = 64;
  localparam int WIDTH_W    = 7;
  localparam int KEY_ADDR_W = 8;
  localparam int MAX_KEYS   = 2 ** KEY_ADDR_W;
  localparam int KEY_CNT_W  = KEY_ADDR_W + 1;
  localparam int COUNT_W    = 16;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [COUNT_W-1:0]   COUNT_MAX    = '1;
  localparam logic [KEY_CNT_W-1:0] KEYS_FULL    = KEY_CNT_W'(MAX_KEYS);
  localparam logic [WIDTH_W-1:0]   WIDTH_RESET  = WIDTH_W'(ROW_BITS);
  localparam logic                 REG_ROW_WIDTH = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } scan_state_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [ROW_BITS-1:0] key;
  } key_entry_t;

  typedef struct packed {
    logic [COUNT_W-1:0] best_count;
    logic [COUNT_W-1:0] row_key_count;
    logic               table_overflow;
  } row_result_t;

  typedef struct packed {
    logic                 busy;
    logic [KEY_CNT_W-1:0] keys_in_use;
  } scan_status_t;

  // Restrict a row to the active columns and invert it when column 0 is set.
  function automatic logic [ROW_BITS-1:0] norm_key(input logic [ROW_BITS-1:0] row,
                                                   input logic [WIDTH_W-1:0]  width);
    logic [ROW_BITS-1:0] mask;
    logic [ROW_BITS-1:0] key;
    if (width == '0) begin
      mask = ROW_BITS'(1);
    end else if (width >= WIDTH_W'(ROW_BITS)) begin
      mask = '1;
    end else begin
      mask = ~({ROW_BITS{1'b1}} << width[$clog2(ROW_BITS)-1:0]);
    end
    key = row & mask;
    if (key[0]) begin
      key = key ^ mask;
    end
    return key;
  endfunction

endpackage

@@ hw/rtl/nrkf_key_ram.sv @@
// Key table memory: one entry per distinct key, holding the key and its count.
// Single write port, single read port with registered read data. Uses nrkf_pkg.
`timescale 1ns / 1ps

module nrkf_key_ram (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [nrkf_pkg::KEY_ADDR_W-1:0] wr_addr,
  input  nrkf_pkg::key_entry_t            wr_data,
  input  logic                            rd_en,
  input  logic [nrkf_pkg::KEY_ADDR_W-1:0] rd_addr,
  output nrkf_pkg::key_entry_t            rd_data
);
  import nrkf_pkg::*;

  key_entry_t mem [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/nrkf_scan.sv @@
// Sequencer that walks the key table with one shared 64-bit key comparator,
// then updates the matching or new entry and forms the result. Uses nrkf_pkg.
`timescale 1ns / 1ps

module nrkf_scan (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [nrkf_pkg::ROW_BITS-1:0]   key_in,
  input  logic                            new_matrix,
  input  logic                            res_ready,
  output logic                            res_valid,
  output nrkf_pkg::row_result_t           result,
  output nrkf_pkg::scan_status_t          status,
  output logic                            ram_wr_en,
  output logic [nrkf_pkg::KEY_ADDR_W-1:0] ram_wr_addr,
  output nrkf_pkg::key_entry_t            ram_wr_data,
  output logic                            ram_rd_en,
  output logic [nrkf_pkg::KEY_ADDR_W-1:0] ram_rd_addr,
  input  nrkf_pkg::key_entry_t            ram_rd_data
);
  import nrkf_pkg::*;

  scan_state_t state, state_next;

  logic [ROW_BITS-1:0]   key;
  logic [KEY_CNT_W-1:0]  keys_in_use;
  logic [COUNT_W-1:0]    running_best;
  logic [KEY_CNT_W-1:0]  scan_idx;
  logic                  cmp_valid;
  logic [KEY_ADDR_W-1:0] cmp_idx;
  logic                  found;
  logic [KEY_ADDR_W-1:0] hit_idx;
  logic [COUNT_W-1:0]    hit_count;

  logic               hit_now;
  logic               issue;
  logic               table_full;
  logic [COUNT_W-1:0] row_count;
  logic [COUNT_W-1:0] best_next;
  logic               commit;

  assign hit_now    = (state == ST_SCAN) && cmp_valid && (ram_rd_data.key == key);
  assign table_full = (keys_in_use == KEYS_FULL);
  assign commit     = res_valid && res_ready;

  always_comb begin
    if (found) begin
      row_count = (hit_count == COUNT_MAX) ? COUNT_MAX : hit_count + COUNT_W'(1);
    end else if (!table_full) begin
      row_count = COUNT_W'(1);
    end else begin
      row_count = '0;
    end
    best_next = (row_count > running_best) ? row_count : running_best;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit_now || (!cmp_valid && scan_idx >= keys_in_use)) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    issue       = 1'b0;
    res_valid   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = keys_in_use[KEY_ADDR_W-1:0];
    ram_wr_data = '{count: row_count, key: key};
    unique case (state)
      ST_IDLE: begin
      end
      ST_SCAN: begin
        issue = !hit_now && (scan_idx < keys_in_use);
      end
      ST_UPDATE: begin
        res_valid = 1'b1;
        ram_wr_en = res_ready && (found || !table_full);
        if (found) begin
          ram_wr_addr = hit_idx;
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_rd_en   = issue;
  assign ram_rd_addr = scan_idx[KEY_ADDR_W-1:0];

  assign result.best_count     = best_next;
  assign result.row_key_count  = row_count;
  assign result.table_overflow = !found && table_full;

  assign status.busy        = (state != ST_IDLE);
  assign status.keys_in_use = keys_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      keys_in_use  <= '0;
      running_best <= '0;
      cmp_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= issue;
      if (start && state == ST_IDLE && new_matrix) begin
        keys_in_use  <= '0;
        running_best <= '0;
      end
      if (commit) begin
        running_best <= best_next;
        if (!found && !table_full) begin
          keys_in_use <= keys_in_use + KEY_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && state == ST_IDLE) begin
      key      <= key_in;
      scan_idx <= '0;
      found    <= 1'b0;
    end else begin
      if (issue) begin
        scan_idx <= scan_idx + KEY_CNT_W'(1);
        cmp_idx  <= scan_idx[KEY_ADDR_W-1:0];
      end
      if (hit_now) begin
        found     <= 1'b1;
        hit_idx   <= cmp_idx;
        hit_count <= ram_rd_data.count;
      end
    end
  end

endmodule

@@ hw/rtl/normalized_row_key_frequency_max.sv @@
// Top level of the normalized row key frequency block: register port, key
// normalizing, result register. Uses nrkf_pkg, nrkf_key_ram and nrkf_scan.
`timescale 1ns / 1ps

// Usage:
// Each input item carries one matrix row (row_bits) and a first_row flag that
// empties the key table and the running maximum before the row is counted.
// The row is masked to row_width columns and inverted when column 0 is set.
// Each item gives one result item: best_count, the row's key count after the
// update, and table_overflow when a new key could not be stored.
// With keys in the table, the sequencer reads one stored key per cycle from the
// key memory and compares it with the single key comparator, until a match or
// the end of the table; an empty table goes straight to the update step.
// in_ready returns in the same cycle as the result enters the output register,
// so the block takes no new item until the last one has been counted.
// The result sits in an output register, so the next item is accepted while a
// result still waits. When the receiver stalls with a result pending, the next
// item stops before its update step and resumes once the output register frees.
// row_width is written over the APB port at address 0; the user must do so only
// while the block is idle, and the block itself does not enforce this.
// Reset empties the table, clears the running maximum and sets row_width to 64.

module normalized_row_key_frequency_max (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nrkf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [nrkf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [nrkf_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [nrkf_pkg::ROW_BITS-1:0]   row_bits,
  input  logic                            first_row,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [nrkf_pkg::COUNT_W-1:0]    best_count,
  output logic [nrkf_pkg::COUNT_W-1:0]    row_key_count,
  output logic                            table_overflow
);
  import nrkf_pkg::*;

  logic [WIDTH_W-1:0] row_width;
  logic               reg_index;
  logic               start;
  logic               res_valid;
  logic               res_ready;
  row_result_t        result;
  scan_status_t       status;

  logic                  ram_wr_en;
  logic [KEY_ADDR_W-1:0] ram_wr_addr;
  key_entry_t            ram_wr_data;
  logic                  ram_rd_en;
  logic [KEY_ADDR_W-1:0] ram_rd_addr;
  key_entry_t            ram_rd_data;

  assign reg_index = paddr[APB_ADDR_W-1];
  assign pready    = 1'b1;

  always_comb begin
    prdata = '0;
    if (reg_index == REG_ROW_WIDTH) begin
      prdata = APB_DATA_W'(row_width);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && reg_index == REG_ROW_WIDTH) begin
      row_width <= pwdata[WIDTH_W-1:0];
    end
  end

  assign in_ready  = !status.busy;
  assign start     = in_valid && in_ready;
  assign res_ready = !out_valid || out_ready;

  nrkf_key_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  nrkf_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .key_in      (norm_key(row_bits, row_width)),
    .new_matrix  (first_row),
    .res_ready   (res_ready),
    .res_valid   (res_valid),
    .result      (result),
    .status      (status),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      best_count     <= result.best_count;
      row_key_count  <= result.row_key_count;
      table_overflow <= result.table_overflow;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted item keeps the sequencer busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready)
    else $error("sequencer not busy after an accepted item");

  // The fill count never runs past the table depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    status.keys_in_use <= KEYS_FULL)
    else $error("key table fill count out of range");

  // A dropped key reports a zero count.
  a_overflow_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_overflow |-> row_key_count == '0)
    else $error("dropped key with nonzero count");

  // The running maximum covers the count of the row just reported.
  a_best_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> best_count >= row_key_count)
    else $error("best_count below row_key_count");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Testbench for normalized_row_key_frequency_max: feeds matrix rows under random gaps and
// receiver stalls, predicts each result in a scoreboard class and checks it field by field.
// Depends on nrkf_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import nrkf_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 300;
  localparam int unsigned PHASE_ROWS    = 40;
  localparam int unsigned MAX_PRINTS    = 40;
  localparam longint unsigned TIMEOUT_NS = 64'd120_000_000;
  localparam logic [APB_ADDR_W-1:0] ROW_WIDTH_ADDR = APB_ADDR_W'(4 * int'(REG_ROW_WIDTH));

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ROW_BITS-1:0]   row_bits = '0;
  logic                  first_row = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COUNT_W-1:0]    best_count;
  logic [COUNT_W-1:0]    row_key_count;
  logic                  table_overflow;

  normalized_row_key_frequency_max dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Keeps its own key table and predicts the result of every accepted row.
  class flip_row_counter;
    logic [ROW_BITS-1:0] key_store[MAX_KEYS];
    logic [COUNT_W-1:0]  key_counts[MAX_KEYS];
    int unsigned         keys_used;
    logic [COUNT_W-1:0]  best;
    logic [WIDTH_W-1:0]  row_width;
    row_result_t         pending[$];
    int unsigned         errors;

    function new();
      keys_used = 0;
      best      = '0;
      row_width = WIDTH_RESET;
      errors    = 0;
    endfunction

    function void set_width(logic [WIDTH_W-1:0] w);
      row_width = w;
    endfunction

    function logic [ROW_BITS-1:0] col_mask();
      int unsigned w;
      w = row_width;
      if (w < 1) w = 1;
      if (w > ROW_BITS) w = ROW_BITS;
      if (w == ROW_BITS) return '1;
      return (ROW_BITS'(1) << w) - ROW_BITS'(1);
    endfunction

    function void note_row(logic [ROW_BITS-1:0] row, logic first);
      logic [ROW_BITS-1:0] mask;
      logic [ROW_BITS-1:0] key;
      row_result_t         want;
      int                  hit;
      int                  i;
      mask = col_mask();
      key  = row & mask;
      if (first) begin
        keys_used = 0;
        best      = '0;
      end
      if (key[0]) key = key ^ mask;
      hit = -1;
      for (i = 0; i < keys_used; i++) begin
        if (key_store[i] == key) begin
          hit = i;
          break;
        end
      end
      want.table_overflow = 1'b0;
      want.row_key_count  = '0;
      if (hit >= 0) begin
        if (key_counts[hit] != COUNT_MAX) key_counts[hit] = key_counts[hit] + COUNT_W'(1);
        want.row_key_count = key_counts[hit];
      end else if (keys_used < MAX_KEYS) begin
        key_store[keys_used]  = key;
        key_counts[keys_used] = COUNT_W'(1);
        keys_used++;
        want.row_key_count = COUNT_W'(1);
      end else begin
        want.table_overflow = 1'b1;
      end
      if (want.row_key_count > best) best = want.row_key_count;
      want.best_count = best;
      pending = {pending, want};
    endfunction

    task report(string what);
      if (errors < MAX_PRINTS) $display("mismatch at %0t ns: %s", $time, what);
      errors++;
    endtask

    task check_result(row_result_t got);
      row_result_t want;
      if (pending.size() == 0) begin
        report("result item with no row waiting");
        return;
      end
      want = pending.pop_front();
      if (got.best_count !== want.best_count)
        report($sformatf("best_count %0d, predicted %0d", got.best_count, want.best_count));
      if (got.row_key_count !== want.row_key_count)
        report($sformatf("row_key_count %0d, predicted %0d",
                         got.row_key_count, want.row_key_count));
      if (got.table_overflow !== want.table_overflow)
        report($sformatf("table_overflow %b, predicted %b",
                         got.table_overflow, want.table_overflow));
    endtask
  endclass

  flip_row_counter tally;
  int unsigned     send_quiet = 0;
  int unsigned     take_quiet = 0;

  // Mostly random gaps, with occasional runs of back-to-back items.
  function automatic int unsigned draw_gap(inout int unsigned quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  function automatic logic [ROW_BITS-1:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  // Keeps the active columns of base, or their inverse, and fills the rest with noise,
  // so the row lands on the same key as base.
  function automatic logic [ROW_BITS-1:0] same_key_row(logic [ROW_BITS-1:0] base,
                                                       logic [ROW_BITS-1:0] mask);
    logic [ROW_BITS-1:0] act;
    act = ($urandom_range(0, 1) == 1) ? ~base : base;
    return (act & mask) | (rand_row() & ~mask);
  endfunction

  task automatic send_row(input logic [ROW_BITS-1:0] row, input logic first);
    int unsigned gap;
    gap = draw_gap(send_quiet);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    row_bits  <= row;
    first_row <= first;
    do @(posedge clk); while (!in_ready);
    tally.note_row(row, first);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tally.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_width(input logic [WIDTH_W-1:0] w);
    logic [APB_DATA_W-1:0] word;
    word = $urandom;
    word[WIDTH_W-1:0] = w;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROW_WIDTH_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tally.set_width(w);
  endtask

  task automatic run_phase(input logic [WIDTH_W-1:0] w, input logic big);
    logic [ROW_BITS-1:0] pool[$];
    logic [ROW_BITS-1:0] mask;
    logic [ROW_BITS-1:0] row;
    int unsigned         sent;
    int unsigned         rows;
    int unsigned         n;
    write_row_width(w);
    mask = tally.col_mask();
    sent = 0;
    if (big) begin
      // Fresh rows until the table is full, then a mix, so later new keys are dropped.
      pool.delete();
      rows = $urandom_range(290, 330);
      for (n = 0; n < rows; n++) begin
        if (n >= MAX_KEYS && $urandom_range(0, 1) == 0)
          row = same_key_row(pool[$urandom_range(0, pool.size() - 1)], mask);
        else
          row = rand_row();
        pool = {pool, row};
        send_row(row, n == 0);
      end
    end
    while (sent < PHASE_ROWS) begin
      pool.delete();
      repeat ($urandom_range(1, 6)) pool = {pool, rand_row()};
      rows = $urandom_range(1, 40);
      for (n = 0; n < rows; n++) begin
        if ($urandom_range(0, 6) == 0)
          row = rand_row();
        else
          row = same_key_row(pool[$urandom_range(0, pool.size() - 1)], mask);
        // Some matrices skip the first_row flag and extend the previous table.
        send_row(row, (n == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0));
      end
      sent += rows;
    end
    settle();
  endtask

  initial begin : result_taker
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      // Two long holds let the block fill up and stall the sender.
      gap = (taken == 400 || taken == 1000) ? HOLD_CYCLES : draw_gap(take_quiet);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tally.check_result({best_count, row_key_count, table_overflow});
      taken++;
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    tally = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Full width from reset; rows before any first_row start from the empty table.
    send_row('0, 1'b0);
    send_row('1, 1'b0);
    send_row(64'h8000_0000_0000_0000, 1'b1);
    send_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_row(64'h5555_5555_5555_5555, 1'b0);
    send_row(64'h5555_5555_5555_5555, 1'b0);
    send_row(64'h0000_0000_0000_0002, 1'b0);
    send_row(64'hFFFF_FFFF_FFFF_FFFD, 1'b0);
    settle();

    // A width of zero acts as one column, so every row maps to the all-zero key.
    write_row_width('0);
    send_row(64'h1234_5678_9ABC_DEF1, 1'b1);
    send_row('1, 1'b0);
    send_row('0, 1'b0);
    settle();

    write_row_width('1);
    send_row(64'hF0F0_F0F0_F0F0_F0F0, 1'b1);
    send_row(64'h0F0F_0F0F_0F0F_0F0F, 1'b0);
    settle();

    // The top column lies outside a width of 63 and must not change the key.
    write_row_width(WIDTH_W'(63));
    send_row(64'h8000_0000_0000_0000, 1'b1);
    send_row('0, 1'b0);
    send_row(64'h4000_0000_0000_0000, 1'b0);
    send_row(64'hBFFF_FFFF_FFFF_FFFF, 1'b0);
    settle();

    run_phase(WIDTH_W'(1), 1'b0);
    run_phase(WIDTH_W'(64), 1'b1);
    run_phase(WIDTH_W'(2), 1'b0);
    run_phase(WIDTH_W'($urandom_range(3, 16)), 1'b0);
    run_phase(WIDTH_W'($urandom_range(17, 63)), 1'b0);
    run_phase('1, 1'b1);
    run_phase(WIDTH_W'($urandom_range(65, 126)), 1'b0);
    run_phase('0, 1'b0);
    run_phase(WIDTH_W'($urandom_range(1, 64)), 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tally.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/nrkf_pkg.sv
hw/rtl/nrkf_key_ram.sv
hw/rtl/nrkf_scan.sv
hw/rtl/normalized_row_key_frequency_max.sv
tb/sv/tb.sv
